// ===== rtl/mhd_pkg.sv =====
`default_nettype none

package mhd_pkg;

  // Parser state codes
  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_MAGIC1  = 3'd1;
  localparam logic [2:0] ST_MAGIC2  = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_PAYLOAD = 3'd4;
  localparam logic [2:0] ST_WAIT    = 3'd5;

  // Input function codes
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Header and frame constants
  localparam logic [7:0] MAGIC_0     = 8'hDC;
  localparam logic [7:0] MAGIC_1     = 8'hCD;
  localparam logic [7:0] VERSION_1   = 8'h01;
  localparam logic [7:0] OPTS_SHORT  = 8'h03;
  localparam logic [7:0] OPTS_LONG   = 8'h07;
  localparam logic [7:0] TERMINATOR  = 8'h00;

  localparam int unsigned INDEX_W = 11;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } mhd_in_t;

  typedef struct packed {
    logic               accepted;
    logic               released;
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic [INDEX_W-1:0] payload_index;
    logic               message_end;
    logic [2:0]         frame_options;
    logic [2:0]         frame_state;
  } mhd_out_t;

endpackage

`default_nettype wire

// ===== rtl/mhd_in_stage.sv =====
`default_nettype none

module mhd_in_stage
  import mhd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    byte_valid,
  output logic         byte_ready,
  input  wire mhd_in_t byte_item,
  output logic         item_valid,
  output mhd_in_t      item,
  input  wire logic    item_take
);

  logic    vld;
  mhd_in_t data;

  // Take a new item when empty or when the held one moves on this cycle
  assign byte_ready = !vld || item_take;
  assign item_valid = vld;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (byte_ready) begin
      vld <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      data <= byte_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhd_core.sv =====
`default_nettype none

module mhd_core
  import mhd_pkg::*;
#(
  parameter int unsigned MSG_DEPTH = 2048
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire mhd_in_t item,
  output mhd_out_t     result
);

  localparam int unsigned POS_W = $clog2(MSG_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MSG_DEPTH - 1);

  logic [2:0]       parse_state;
  logic [2:0]       parse_state_next;
  logic [POS_W-1:0] write_position;
  logic [POS_W-1:0] write_position_next;
  logic [2:0]       options_seen;
  logic [2:0]       options_seen_next;
  logic [POS_W+INDEX_W-1:0] pos_ext;

  assign pos_ext = {{INDEX_W{1'b0}}, write_position};

  always_comb begin
    parse_state_next    = parse_state;
    write_position_next = write_position;
    options_seen_next   = options_seen;
    result              = '0;

    if (item.func == FUNC_BYTE) begin
      if (parse_state != ST_WAIT) begin
        result.accepted = 1'b1;
        case (parse_state)
          ST_HUNT: begin
            if (item.data_byte == MAGIC_0) begin
              parse_state_next = ST_MAGIC1;
            end
          end
          ST_MAGIC1: begin
            parse_state_next = (item.data_byte == MAGIC_1) ? ST_MAGIC2 : ST_HUNT;
          end
          ST_MAGIC2: begin
            parse_state_next = (item.data_byte == VERSION_1) ? ST_VERSION : ST_HUNT;
          end
          ST_VERSION: begin
            if (item.data_byte == OPTS_SHORT || item.data_byte == OPTS_LONG) begin
              parse_state_next    = ST_PAYLOAD;
              options_seen_next   = item.data_byte[2:0];
              write_position_next = '0;
            end else begin
              parse_state_next = ST_HUNT;
            end
          end
          ST_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = item.data_byte;
            result.payload_index = pos_ext[INDEX_W-1:0];
            // Saturate at the last slot
            if (write_position < LAST_POS) begin
              write_position_next = write_position + 1'b1;
            end
            if (item.data_byte == TERMINATOR) begin
              result.message_end = 1'b1;
              parse_state_next   = ST_WAIT;
            end
          end
          default: begin
            parse_state_next = ST_HUNT;
          end
        endcase
      end
    end else begin
      if (parse_state == ST_WAIT) begin
        result.released  = 1'b1;
        parse_state_next = ST_HUNT;
      end
    end

    result.frame_options = options_seen_next;
    result.frame_state   = parse_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state    <= ST_HUNT;
      write_position <= '0;
      options_seen   <= '0;
    end else if (fire) begin
      parse_state    <= parse_state_next;
      write_position <= write_position_next;
      options_seen   <= options_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhd_out_buf.sv =====
`default_nettype none

module mhd_out_buf
  import mhd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire mhd_out_t push_item,
  output logic          room,
  output logic          res_valid,
  input  wire logic     res_ready,
  output mhd_out_t      res_item
);

  mhd_out_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room      = (count != 2'd2);
  assign res_valid = (count != 2'd0);
  assign res_item  = slot[rd_ptr];
  assign pop       = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/magic_header_frame_deframer_unit.sv =====
// An accepted item passes the input register, then the result buffer, before its result
// is offered; the parser steps the item only when the result buffer has a free slot.
// Throughput: one item per cycle while the result buffer has room; the two-entry result
// buffer holds results through output stalls and the input register keeps ready off any long path.
// Reset: synchronous active-high rst empties both stages, puts the parser in hunt,
// and clears write position and options.
`default_nettype none

module magic_header_frame_deframer_unit
  import mhd_pkg::*;
#(
  parameter int unsigned MSG_DEPTH = 2048
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire mhd_in_t  byte_item,
  output logic          res_valid,
  input  wire logic     res_ready,
  output mhd_out_t      res_item
);

  // Held input item waiting for the parser
  logic     item_valid;
  mhd_in_t  item;
  // Parser step on the held item
  mhd_out_t step_result;
  logic     room;
  logic     fire;

  // Advance an item through the parser only when the result buffer has a free slot;
  // the parser state moves in the same cycle, so each item sees the state left by
  // the previous one.
  assign fire = item_valid && room;

  mhd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (fire)
  );

  // Header hunt, payload indexing and release handling
  mhd_core #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (step_result)
  );

  // Hold results until the consumer takes them
  mhd_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_item (step_result),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

// ===== rtl/mhd_checker.sv =====
`default_nettype none

module mhd_checker
  import mhd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     res_valid,
  input wire logic     res_ready,
  input wire mhd_out_t res_item
);

  // A stalled result stays offered with the same item
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result dropped or changed while stalled");

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !res_valid)
    else $error("result offered right after reset");

  // A payload byte is always a consumed byte and never a release
  a_payload_consumed: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.payload_valid |-> res_item.accepted && !res_item.released &&
      (res_item.frame_state == ST_PAYLOAD || res_item.frame_state == ST_WAIT))
    else $error("payload reported outside a consumed byte");

  // Terminator moves the parser to waiting and carries a zero byte
  a_end_wait: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.message_end |->
      res_item.payload_valid && res_item.payload_byte == TERMINATOR &&
      res_item.frame_state == ST_WAIT)
    else $error("message end without terminator or wait state");

  // A release consumes nothing and ends in hunt
  a_release_hunt: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.released |-> !res_item.accepted &&
      res_item.frame_state == ST_HUNT)
    else $error("release result inconsistent");

endmodule

bind magic_header_frame_deframer_unit mhd_checker u_mhd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_item   (res_item)
);

`default_nettype wire

// ===== test/magic_header_frame_deframer_unit_test.sv =====
`default_nettype none

module magic_header_frame_deframer_unit_test;
  import mhd_pkg::*;

  localparam int unsigned STORE_DEPTH = 2048;
  localparam int          RANDOM_ITEMS = 1550;
  localparam int          CALM_TAIL = 200;
  localparam int          STALL_LIMIT = 1000;
  localparam int          MAX_REPORTS = 10;

  // One byte-side item plus a flag asking the sender to let the block drain first.
  typedef struct {
    mhd_in_t item;
    bit      drain;
  } feed_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_ready;
  mhd_in_t  byte_item = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  mhd_out_t res_item;

  // Items waiting to be sent, and frame results waiting to come back.
  feed_t    feed_q[$];
  mhd_out_t due_q[$];

  // Predicted parser state: header progress, store position and frame options.
  logic [2:0]  hdr_state = ST_HUNT;
  int unsigned store_pos = 0;
  logic [2:0]  frame_opts = '0;

  int n_total = 0;
  int n_issued = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_bad = 0;
  int quiet = 0;
  int snd_gap = 0;
  int rcv_gap = 0;
  bit calm = 1'b0;
  bit took;
  bit gave;
  feed_t    nxt;
  mhd_out_t want;

  magic_header_frame_deframer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted parser by one item and return the result it should give.
  function automatic mhd_out_t deframe(mhd_in_t it);
    mhd_out_t r;
    r = '0;
    if (it.func == FUNC_BYTE) begin
      // Drop bytes outright while a finished message waits for release.
      if (hdr_state != ST_WAIT) begin
        r.accepted = 1'b1;
        case (hdr_state)
          ST_HUNT: begin
            if (it.data_byte == MAGIC_0) hdr_state = ST_MAGIC1;
          end
          ST_MAGIC1: begin
            hdr_state = (it.data_byte == MAGIC_1) ? ST_MAGIC2 : ST_HUNT;
          end
          ST_MAGIC2: begin
            hdr_state = (it.data_byte == VERSION_1) ? ST_VERSION : ST_HUNT;
          end
          ST_VERSION: begin
            if (it.data_byte == OPTS_SHORT || it.data_byte == OPTS_LONG) begin
              hdr_state = ST_PAYLOAD;
              frame_opts = it.data_byte[2:0];
              store_pos = 0;
            end else begin
              hdr_state = ST_HUNT;
            end
          end
          ST_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_byte = it.data_byte;
            r.payload_index = store_pos[INDEX_W-1:0];
            // Saturate at the last slot so overflow bytes overwrite it.
            if (store_pos < STORE_DEPTH - 1) store_pos++;
            if (it.data_byte == TERMINATOR) begin
              r.message_end = 1'b1;
              hdr_state = ST_WAIT;
            end
          end
          default: begin
            hdr_state = ST_HUNT;
          end
        endcase
      end
    end else if (hdr_state == ST_WAIT) begin
      r.released = 1'b1;
      hdr_state = ST_HUNT;
    end
    r.frame_options = frame_opts;
    r.frame_state = hdr_state;
    return r;
  endfunction

  task automatic push_item(logic f, logic [7:0] b, bit drain);
    feed_t e;
    e.item.func = f;
    e.item.data_byte = b;
    e.drain = drain;
    feed_q.push_back(e);
  endtask

  // Queue the first depth bytes of a valid header.
  task automatic push_header(int depth, bit drain);
    if (depth > 0) push_item(FUNC_BYTE, MAGIC_0, drain);
    if (depth > 1) push_item(FUNC_BYTE, MAGIC_1, 1'b0);
    if (depth > 2) push_item(FUNC_BYTE, VERSION_1, 1'b0);
  endtask

  // Queue one well-formed frame with random nonzero payload, then release it.
  // Sprinkle in stray releases during payload and dropped bytes while waiting.
  task automatic push_frame(logic [7:0] opts, int len, bit drain);
    int extra;
    push_header(3, drain);
    push_item(FUNC_BYTE, opts, 1'b0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) push_item(FUNC_RELEASE, 8'($urandom), 1'b0);
      push_item(FUNC_BYTE, 8'($urandom_range(1, 255)), 1'b0);
    end
    push_item(FUNC_BYTE, TERMINATOR, 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) push_item(FUNC_BYTE, 8'($urandom), 1'b0);
    end
    push_item(FUNC_RELEASE, 8'($urandom), 1'b0);
  endtask

  // Queue a header cut short by a byte that does not fit at that depth.
  task automatic push_broken(int depth);
    logic [7:0] b;
    push_header(depth, 1'b0);
    do begin
      b = 8'($urandom);
    end while ((depth == 0 && b == MAGIC_0) || (depth == 1 && b == MAGIC_1) ||
               (depth == 2 && b == VERSION_1) ||
               (depth == 3 && (b == OPTS_SHORT || b == OPTS_LONG)));
    push_item(FUNC_BYTE, b, 1'b0);
  endtask

  // Sender and receiver: change inputs on the falling edge only.
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      calm = (n_total - n_issued) < CALM_TAIL;
      if (byte_valid && n_taken != n_issued) begin
        // Hold the offered item until the block takes it.
      end else if (snd_gap > 0) begin
        snd_gap--;
        byte_valid <= 1'b0;
      end else if (feed_q.size() != 0 && feed_q[0].drain && due_q.size() != 0) begin
        // Pause until every outstanding result has come back.
        byte_valid <= 1'b0;
      end else if (feed_q.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
        snd_gap = $urandom_range(1, 15) - 1;
        byte_valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        nxt = feed_q.pop_front();
        byte_item <= nxt.item;
        byte_valid <= 1'b1;
        n_issued++;
      end else begin
        byte_valid <= 1'b0;
      end

      if (rcv_gap > 0) begin
        rcv_gap--;
        res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        rcv_gap = $urandom_range(1, 15) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Monitor: sample both handshakes on the rising edge, predict, compare, watch for hangs.
  always @(posedge clk) begin
    if (!rst) begin
      took = byte_valid && byte_ready;
      gave = res_valid && res_ready;
      if (took) begin
        due_q.push_back(deframe(byte_item));
        n_taken++;
      end
      if (gave) begin
        if (due_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: acc=%b rel=%b pv=%b byte=%h",
                     n_results, res_item.accepted, res_item.released,
                     res_item.payload_valid, res_item.payload_byte);
        end else begin
          want = due_q.pop_front();
          if (res_item.accepted !== want.accepted || res_item.released !== want.released ||
              res_item.payload_valid !== want.payload_valid ||
              res_item.payload_byte !== want.payload_byte ||
              res_item.payload_index !== want.payload_index ||
              res_item.message_end !== want.message_end ||
              res_item.frame_options !== want.frame_options ||
              res_item.frame_state !== want.frame_state) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS) begin
              $display("result %0d expected acc=%b rel=%b pv=%b byte=%h idx=%0d end=%b opt=%0d st=%0d",
                       n_results, want.accepted, want.released, want.payload_valid,
                       want.payload_byte, want.payload_index, want.message_end,
                       want.frame_options, want.frame_state);
              $display("result %0d actual   acc=%b rel=%b pv=%b byte=%h idx=%0d end=%b opt=%0d st=%0d",
                       n_results, res_item.accepted, res_item.released, res_item.payload_valid,
                       res_item.payload_byte, res_item.payload_index, res_item.message_end,
                       res_item.frame_options, res_item.frame_state);
            end
          end
        end
        n_results++;
      end
      if (took || gave) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int pick;
    int len;
    bit first;

    // Directed: release with nothing waiting, every header mismatch depth,
    // a short message, a byte while waiting, double release, empty message.
    push_item(FUNC_RELEASE, 8'h00, 1'b0);
    push_item(FUNC_BYTE, MAGIC_0, 1'b0);
    push_item(FUNC_BYTE, 8'h00, 1'b0);
    push_header(2, 1'b0);
    push_item(FUNC_BYTE, 8'h02, 1'b0);
    push_header(3, 1'b0);
    push_item(FUNC_BYTE, 8'h05, 1'b0);
    push_header(3, 1'b0);
    push_item(FUNC_BYTE, OPTS_SHORT, 1'b0);
    push_item(FUNC_BYTE, 8'hFF, 1'b0);
    push_item(FUNC_BYTE, 8'h80, 1'b0);
    push_item(FUNC_BYTE, TERMINATOR, 1'b0);
    push_item(FUNC_BYTE, 8'h55, 1'b0);
    push_item(FUNC_RELEASE, 8'hFF, 1'b0);
    push_item(FUNC_RELEASE, 8'h00, 1'b0);
    push_frame(OPTS_LONG, 0, 1'b0);

    // Random: mostly well-formed frames, mixed with broken headers, noise and stray releases.
    first = 1'b1;
    while (feed_q.size() < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 24);
        push_frame($urandom_range(0, 1) ? OPTS_SHORT : OPTS_LONG, len,
                   first || $urandom_range(0, 39) == 0);
        first = 1'b0;
      end else if (pick < 85) begin
        len = $urandom_range(0, 3);
        push_broken(len);
      end else if (pick < 95) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_item(FUNC_BYTE, 8'($urandom), 1'b0);
      end else begin
        push_item(FUNC_RELEASE, 8'($urandom), 1'b0);
      end
    end
    n_total = feed_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all items to go in and all results to come out, then let the pipe settle.
    while (n_taken != n_total || due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (n_bad == 0 && due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
